>>> rtl/greedy_word_wrap_core_macros.svh
// Assertion macros for the word wrap core
`ifndef GREEDY_WORD_WRAP_CORE_MACROS_SVH
`define GREEDY_WORD_WRAP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define GWW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("word wrap check failed");

// Next-cycle implication, disabled while reset is held
`define GWW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("word wrap check failed");

`endif

>>> rtl/gww_pkg.sv
// Shared types and constants of the word wrap core
package gww_pkg;

    localparam int          CHAR_W         = 8;
    localparam int          LINE_WIDTH_W   = 6;
    localparam int          COL_W          = 7;
    localparam int          MAX_LINE_DEF   = 64;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 6'd63;
    localparam logic [COL_W-1:0]        COL_MAX        = 7'd127;
    localparam logic [CHAR_W-1:0]       CH_NL          = 8'h0A;
    localparam logic [CHAR_W-1:0]       CH_SP          = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REL_BYTES,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic out_free;
        logic acc_release;
        logic acc_held_nz;
        logic acc_tail;
        logic tail_pend;
        logic rd_last;
    } t_dp_status;

    typedef struct packed {
        logic accept;
        logic load_byte;
        logic load_tail;
        logic rd_inc;
        logic rd_clear;
    } t_dp_cmd;

endpackage

>>> rtl/gww_ram.sv
// Generic single-write, single-read RAM with registered read data
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gww_ctrl.sv
// Sequencer of the word wrap core: accept, held byte release, final result
module gww_ctrl
    import gww_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_status.acc_release) begin
                    if (i_status.acc_held_nz) begin
                        n_state = ST_REL_BYTES;
                    end else if (i_status.acc_tail) begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_REL_BYTES: begin
                if (i_status.out_free && i_status.rd_last) begin
                    n_state = i_status.tail_pend ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready   = i_status.out_free;
                o_cmd.accept = i_s_tvalid && i_status.out_free;
            end
            ST_REL_BYTES: begin
                if (i_status.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    o_cmd.rd_inc    = !i_status.rd_last;
                    o_cmd.rd_clear  = i_status.rd_last;
                end
            end
            ST_TAIL: begin
                o_cmd.load_tail = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/gww_dp.sv
// Datapath of the word wrap core: column tracking, held bytes, output register
module gww_dp
    import gww_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [LINE_WIDTH_W-1:0] i_cfg_data,
    input  logic [CHAR_W-1:0]       i_char,
    input  logic                    i_end,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [CHAR_W-1:0]       o_out_char,
    output logic                    o_out_end,
    output logic                    o_out_last
);

    localparam int                IDX_W   = $clog2(MAX_LINE);
    localparam logic [COL_W-1:0]  WIDTH_CAP = COL_W'(MAX_LINE - 1);

    logic [LINE_WIDTH_W-1:0] r_line_width;
    logic [COL_W-1:0]        r_col;
    logic [COL_W-1:0]        n_col;
    logic                    r_pending;
    logic                    n_pending;
    logic [IDX_W-1:0]        r_held;
    logic [IDX_W-1:0]        n_held;
    logic [IDX_W-1:0]        r_rel_n;
    logic [IDX_W-1:0]        r_rd_idx;
    logic [IDX_W-1:0]        n_rd_idx;
    logic                    r_tail_valid;
    logic [CHAR_W-1:0]       r_tail_char;
    logic                    r_tail_end;
    logic                    r_o_valid;
    logic [CHAR_W-1:0]       r_o_char;
    logic                    r_o_end;
    logic                    r_o_last;
    logic                    n_o_valid;
    logic [CHAR_W-1:0]       n_o_char;
    logic                    n_o_end;
    logic                    n_o_last;

    logic [COL_W-1:0]        w_width;
    logic [COL_W-1:0]        w_col_inc;
    logic                    w_passes;
    logic                    w_is_nl;
    logic                    w_is_sp;
    logic                    w_release;
    logic [CHAR_W-1:0]       w_rel_char;
    logic                    w_tail;
    logic [CHAR_W-1:0]       w_tail_char;
    logic                    w_hold;
    logic                    w_out_free;
    logic                    w_rd_last;
    logic [CHAR_W-1:0]       w_rd_data;

    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_rd_last  = ({1'b0, r_rd_idx} + 1'b1) == {1'b0, r_rel_n};

    always_comb begin
        w_width   = ({1'b0, r_line_width} > WIDTH_CAP) ? WIDTH_CAP : {1'b0, r_line_width};
        w_col_inc = (r_col < COL_MAX) ? r_col + 1'b1 : r_col;
        w_passes  = w_col_inc > w_width;
        w_is_nl   = i_char == CH_NL;
        w_is_sp   = i_char == CH_SP;

        w_release   = 1'b0;
        w_rel_char  = CH_SP;
        w_tail      = 1'b0;
        w_tail_char = i_char;
        w_hold      = 1'b0;
        n_col       = r_col;
        n_pending   = r_pending;
        n_held      = r_held;

        if (i_end) begin
            w_release   = r_pending;
            w_tail      = 1'b1;
            w_tail_char = '0;
            n_col       = '0;
            n_pending   = 1'b0;
            n_held      = '0;
        end else if (w_is_nl) begin
            w_release = r_pending;
            w_tail    = 1'b1;
            n_col     = '0;
            n_pending = 1'b0;
            n_held    = '0;
        end else if (w_is_sp) begin
            w_release   = r_pending;
            w_tail      = w_passes;
            w_tail_char = CH_NL;
            n_col       = w_passes ? '0 : w_col_inc;
            n_pending   = !w_passes;
            n_held      = '0;
        end else if (w_passes) begin
            w_release  = r_pending;
            w_rel_char = CH_NL;
            w_tail     = 1'b1;
            n_col      = r_pending ? COL_W'(r_held) + 1'b1 : w_col_inc;
            n_pending  = 1'b0;
            n_held     = '0;
        end else if (r_pending) begin
            w_hold = 1'b1;
            n_col  = w_col_inc;
            n_held = r_held + 1'b1;
        end else begin
            w_tail = 1'b1;
            n_col  = w_col_inc;
        end
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.rd_clear) begin
            n_rd_idx = '0;
        end else if (i_cmd.rd_inc) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end
    end

    always_comb begin
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_char  = r_o_char;
        n_o_end   = r_o_end;
        n_o_last  = r_o_last;
        if (i_cmd.accept && w_release) begin
            n_o_valid = 1'b1;
            n_o_char  = w_rel_char;
            n_o_end   = 1'b0;
            n_o_last  = (r_held == '0) && !w_tail;
        end else if (i_cmd.accept && w_tail) begin
            n_o_valid = 1'b1;
            n_o_char  = w_tail_char;
            n_o_end   = i_end;
            n_o_last  = 1'b1;
        end else if (i_cmd.load_byte) begin
            n_o_valid = 1'b1;
            n_o_char  = w_rd_data;
            n_o_end   = 1'b0;
            n_o_last  = w_rd_last && !r_tail_valid;
        end else if (i_cmd.load_tail) begin
            n_o_valid = 1'b1;
            n_o_char  = r_tail_char;
            n_o_end   = r_tail_end;
            n_o_last  = 1'b1;
        end
    end

    gww_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LINE)
    ) u_held_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && w_hold),
        .i_waddr (r_held),
        .i_wdata (i_char),
        .i_raddr (n_rd_idx),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_col        <= '0;
            r_pending    <= 1'b0;
            r_held       <= '0;
            r_rd_idx     <= '0;
            r_tail_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_width <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_col        <= n_col;
                r_pending    <= n_pending;
                r_held       <= n_held;
                r_tail_valid <= w_tail;
            end
            r_rd_idx  <= n_rd_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rel_n     <= r_held;
            r_tail_char <= w_tail_char;
            r_tail_end  <= i_end;
        end
        r_o_char <= n_o_char;
        r_o_end  <= n_o_end;
        r_o_last <= n_o_last;
    end

    assign o_status.out_free    = w_out_free;
    assign o_status.acc_release = w_release;
    assign o_status.acc_held_nz = r_held != '0;
    assign o_status.acc_tail    = w_tail;
    assign o_status.tail_pend   = r_tail_valid;
    assign o_status.rd_last     = w_rd_last;

    assign o_out_valid = r_o_valid;
    assign o_out_char  = r_o_char;
    assign o_out_end   = r_o_end;
    assign o_out_last  = r_o_last;

endmodule

>>> rtl/greedy_word_wrap_core.sv
// Greedy word wrap core: top level joining sequencer and datapath
//
// Byte requests enter on the s_axis channel, one text byte per request, with
// s_axis_tlast marking the end of text (the byte is then ignored). Results
// leave on m_axis, one byte per request; m_axis_tuser flags the end-of-text
// result (data 0) and m_axis_tlast marks the last result caused by one input.
// The line width is written on the cfg channel, which is always ready; write
// it only while the core is idle. Reset value of the width is 63.
// An ordinary byte leaves in the cycle after it is accepted; a new byte is
// taken every cycle unless input stalls. A word byte that pushes a held word
// past the line width, or a space, newline or end marker arriving while a
// space is held, releases the held space (as a newline if a word byte breaks
// the line) and k held bytes: k + 2 results (k + 1 when a space is held again)
// leave one per cycle while the receiver is ready, through the single output
// register, reading the held-byte RAM one entry per cycle; input stalls until
// the release is through. A held byte gives no result when accepted. When the
// receiver stalls, the output register keeps its result and input stops. Reset
// clears column, held state and the output register; the RAM needs no clearing.
module greedy_word_wrap_core
    import gww_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LINE_WIDTH_W-1:0] i_cfg_data,     // line_width
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // in_char
    input  logic                    s_axis_tlast,   // in_end
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // out_char
    output logic                    m_axis_tuser,   // out_end
    output logic                    m_axis_tlast    // out_run_last
);

    `include "greedy_word_wrap_core_macros.svh"

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    gww_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gww_dp #(
        .MAX_LINE (MAX_LINE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_char      (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_end   (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    `GWW_ASSERT_NOW(a_no_accept_in_release, i_clk, i_rst_n,
        w_cmd.load_byte || w_cmd.load_tail, !s_axis_tready)

    `GWW_ASSERT_NOW(a_end_result_shape, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'h00))

    `GWW_ASSERT_NEXT(a_end_direct, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tlast && !w_status.acc_release,
        m_axis_tvalid && m_axis_tuser)

endmodule
